FILE: hdl/atu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the three-channel alarm timer.
// Used by atu_core and three_channel_alarm_timer_unit; no dependencies.

package atu_pkg;

    localparam int NUM_ALARMS_DEF = 3;
    localparam int COUNT_BITS_DEF = 32;

    localparam int ACTION_BITS  = 3;
    localparam int CHANNEL_BITS = 2;
    localparam int WORD_BITS    = 32;

    // Action codes
    localparam logic [ACTION_BITS-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_ARM     = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_CANCEL  = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_SW_START = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_SW_STOP = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_SERVICE = 3'd5;

    typedef struct packed {
        logic [ACTION_BITS-1:0]  action;
        logic [CHANNEL_BITS-1:0] channel;
        logic [WORD_BITS-1:0]    delay;
        logic [WORD_BITS-1:0]    tag;
    } item_t;

    typedef struct packed {
        logic                    fired;
        logic [CHANNEL_BITS-1:0] fired_channel;
        logic [WORD_BITS-1:0]    fired_tag;
        logic [WORD_BITS-1:0]    elapsed;
        logic                    irq_request;
        logic [WORD_BITS-1:0]    now;
    } result_t;

endpackage

FILE: hdl/three_channel_alarm_timer_unit.sv
`timescale 1ns / 1ps
// Top level of the three-channel alarm timer: stream ports and the
// two-entry result buffer. Depends on atu_pkg and atu_core.

// One item is taken per clock cycle while s_axis_tready is high; its result
// is registered on the master side, or in the skid register if the output
// stalls. Every action is a register update, so the sustained rate is one
// item per cycle whenever the result side keeps taking. Results go into an
// output register backed by a skid register: input is refused only while
// both hold results. After reset the valid flags and timer state are clear.

module three_channel_alarm_timer_unit #(
    parameter int NUM_ALARMS = atu_pkg::NUM_ALARMS_DEF,
    parameter int COUNT_BITS = atu_pkg::COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // channel[1:0], delay[33:2], tag[65:34], zero fill [71:66]
    input  logic [71:0]  s_axis_tdata,
    // action[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fired_channel[1:0], fired_tag[33:2], elapsed[65:34],
    // irq_request[66], now[98:67], zero fill [103:99]
    output logic [103:0] m_axis_tdata,
    // fired[0]
    output logic [0:0]   m_axis_tuser
);

    atu_pkg::item_t   item;
    atu_pkg::result_t result;
    atu_pkg::result_t out_reg, out_next;
    atu_pkg::result_t skid_reg, skid_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic in_xfer, out_xfer;

    assign item.action  = s_axis_tuser;
    assign item.channel = s_axis_tdata[1:0];
    assign item.delay   = s_axis_tdata[33:2];
    assign item.tag     = s_axis_tdata[65:34];

    assign s_axis_tready = !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = out_valid_reg && m_axis_tready;

    atu_core #(
        .NUM_ALARMS(NUM_ALARMS),
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(in_xfer),
        .item      (item),
        .result    (result)
    );

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg)
        begin
            // no input transfer possible here
            if (out_xfer)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.fired;
    assign m_axis_tdata  = {5'b0, out_reg.now, out_reg.irq_request, out_reg.elapsed,
                            out_reg.fired_tag, out_reg.fired_channel};

endmodule

FILE: hdl/atu_core.sv
`timescale 1ns / 1ps
// Timer state (counter, alarm channels, stopwatch) and the single-pass
// update for one item. Depends on atu_pkg.

module atu_core #(
    parameter int NUM_ALARMS = atu_pkg::NUM_ALARMS_DEF,
    parameter int COUNT_BITS = atu_pkg::COUNT_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  atu_pkg::item_t  item,
    output atu_pkg::result_t result
);

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] start_reg, start_next;
    logic [COUNT_BITS-1:0] cmp_reg  [NUM_ALARMS];
    logic [COUNT_BITS-1:0] cmp_next [NUM_ALARMS];
    logic [atu_pkg::WORD_BITS-1:0] tag_reg  [NUM_ALARMS];
    logic [atu_pkg::WORD_BITS-1:0] tag_next [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] en_reg, en_next;
    logic [NUM_ALARMS-1:0] pend_reg, pend_next;

    always_comb
    begin
        logic found;
        count_next = count_reg;
        start_next = start_reg;
        cmp_next   = cmp_reg;
        tag_next   = tag_reg;
        en_next    = en_reg;
        pend_next  = pend_reg;
        found      = 1'b0;
        result     = '0;

        case (item.action)
            atu_pkg::ACT_TICK:
            begin
                count_next = count_reg + 1'b1;
                for (int i = 0; i < NUM_ALARMS; i++)
                begin
                    if (count_next == cmp_reg[i])
                        pend_next[i] = 1'b1;
                end
            end
            atu_pkg::ACT_ARM:
            begin
                // channels at or beyond NUM_ALARMS match nothing
                for (int i = 0; i < NUM_ALARMS; i++)
                begin
                    if (int'(item.channel) == i)
                    begin
                        pend_next[i] = 1'b0;
                        cmp_next[i]  = count_reg + COUNT_BITS'(item.delay);
                        tag_next[i]  = item.tag;
                        en_next[i]   = 1'b1;
                    end
                end
            end
            atu_pkg::ACT_CANCEL:
            begin
                for (int i = 0; i < NUM_ALARMS; i++)
                begin
                    if (int'(item.channel) == i)
                    begin
                        en_next[i]   = 1'b0;
                        pend_next[i] = 1'b0;
                    end
                end
            end
            atu_pkg::ACT_SW_START:
            begin
                start_next = count_reg;
            end
            atu_pkg::ACT_SW_STOP:
            begin
                result.elapsed = atu_pkg::WORD_BITS'(count_reg - start_reg);
            end
            atu_pkg::ACT_SERVICE:
            begin
                // lowest-numbered ready channel wins
                for (int i = 0; i < NUM_ALARMS; i++)
                begin
                    if (!found && en_reg[i] && pend_reg[i])
                    begin
                        found                = 1'b1;
                        en_next[i]           = 1'b0;
                        pend_next[i]         = 1'b0;
                        result.fired         = 1'b1;
                        result.fired_channel = atu_pkg::CHANNEL_BITS'(i);
                        result.fired_tag     = tag_reg[i];
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.irq_request = |(en_next & pend_next);
        result.now         = atu_pkg::WORD_BITS'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            start_reg <= '0;
            en_reg    <= '0;
            pend_reg  <= '0;
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                cmp_reg[i] <= '0;
                tag_reg[i] <= '0;
            end
        end
        else if (item_valid)
        begin
            count_reg <= count_next;
            start_reg <= start_next;
            en_reg    <= en_next;
            pend_reg  <= pend_next;
            cmp_reg   <= cmp_next;
            tag_reg   <= tag_next;
        end
    end

endmodule

FILE: hdl/atu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for three_channel_alarm_timer_unit, attached by bind.
// No package dependency.

module atu_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [71:0]  s_axis_tdata,
    input logic [2:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // a stalled result holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // m_axis_tvalid is high on the cycle after every accepted item
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after input transfer");

    // input is refused only while results are waiting
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // no dispatch means zero channel and tag
    a_no_fire_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[33:0] == 34'd0)
        else $error("channel or tag set without a dispatch");

endmodule

bind three_channel_alarm_timer_unit atu_checker u_atu_checker (.*);
